@@ sv/r2d_pkg.sv @@
`default_nettype none
package r2d_pkg;

  localparam int ACC_WIDTH      = 31;
  localparam int MAX_DEC_DIGITS = 10;

  localparam int BCD_W  = 4 * MAX_DEC_DIGITS;
  // acc shifted by up to 4 bits plus an 8-bit digit
  localparam int WIDE_W = ACC_WIDTH + 5;
  localparam int CNT_W  = $clog2(ACC_WIDTH + 1);
  localparam int NDIG_W = $clog2(MAX_DEC_DIGITS + 1);

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  localparam logic [1:0] MODE_BIN = 2'd0;
  localparam logic [1:0] MODE_OCT = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_UPR_A = 8'd65;
  localparam logic [7:0] ASCII_UPR_F = 8'd70;
  localparam logic [7:0] HEX_A_VALUE = 8'd10;

  typedef struct packed {
    logic                 sat;
    logic [ACC_WIDTH-1:0] value;
  } job_t;

endpackage
`default_nettype wire

@@ sv/r2d_front.sv @@
`default_nettype none
module r2d_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_wdata,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_symbol,
  input  wire logic          in_final,
  output logic               in_ready,
  input  wire logic          q_full,
  output logic               q_push,
  output r2d_pkg::job_t      q_job
);

  logic [1:0]                       mode_r;
  logic [r2d_pkg::ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                             sat_r, sat_nxt;
  logic [7:0]                       digit;
  logic [r2d_pkg::WIDE_W-1:0]       wide;
  logic                             ovf;
  logic                             take;

  always_comb begin
    digit = in_symbol;
    if (mode_r == r2d_pkg::MODE_HEX) begin
      if (in_symbol >= r2d_pkg::ASCII_ZERO && in_symbol <= r2d_pkg::ASCII_NINE) begin
        digit = in_symbol - r2d_pkg::ASCII_ZERO;
      end else if (in_symbol >= r2d_pkg::ASCII_UPR_A && in_symbol <= r2d_pkg::ASCII_UPR_F) begin
        digit = in_symbol - r2d_pkg::ASCII_UPR_A + r2d_pkg::HEX_A_VALUE;
      end else begin
        digit = 8'd0;
      end
    end
  end

  always_comb begin
    case (mode_r)
      r2d_pkg::MODE_OCT: wide = r2d_pkg::WIDE_W'(acc_r) << 3;
      r2d_pkg::MODE_HEX: wide = r2d_pkg::WIDE_W'(acc_r) << 4;
      default:           wide = r2d_pkg::WIDE_W'(acc_r) << 1;
    endcase
    wide = wide + r2d_pkg::WIDE_W'(digit);
    // saturate sticky until the final word
    ovf     = sat_r || (wide > r2d_pkg::WIDE_W'(r2d_pkg::ACC_MAX));
    acc_nxt = ovf ? r2d_pkg::ACC_MAX : wide[r2d_pkg::ACC_WIDTH-1:0];
    sat_nxt = ovf;
  end

  assign in_ready    = !q_full;
  assign take        = in_valid && in_ready;
  assign q_push      = take && in_final;
  assign q_job.sat   = sat_nxt;
  assign q_job.value = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= r2d_pkg::MODE_BIN;
      acc_r  <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (take) begin
        if (in_final) begin
          acc_r <= '0;
          sat_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          sat_r <= sat_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/r2d_queue.sv @@
`default_nettype none
module r2d_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire r2d_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output r2d_pkg::job_t      pop_job
);

  r2d_pkg::job_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/r2d_back.sv @@
`default_nettype none
module r2d_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire r2d_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         out_digit,
  output logic               out_last,
  output logic               out_ovf
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [r2d_pkg::CNT_W-1:0]  CONV_STEPS = r2d_pkg::CNT_W'(r2d_pkg::ACC_WIDTH);
  localparam logic [r2d_pkg::NDIG_W-1:0] ALL_DIGITS =
    r2d_pkg::NDIG_W'(r2d_pkg::MAX_DEC_DIGITS);

  logic [1:0]                       state_r;
  logic [r2d_pkg::ACC_WIDTH-1:0]    bin_r;
  logic [r2d_pkg::BCD_W-1:0]        bcd_r;
  logic [r2d_pkg::BCD_W-1:0]        bcd_adj;
  logic [r2d_pkg::CNT_W-1:0]        cnt_r;
  logic [r2d_pkg::NDIG_W-1:0]       ndig_r;
  logic                             sat_r;
  logic [3:0]                       top_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < r2d_pkg::MAX_DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  assign top_digit = bcd_r[r2d_pkg::BCD_W-1 -: 4];
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = (state_r == ST_EMIT);
  assign out_digit = top_digit;
  assign out_last  = (ndig_r == r2d_pkg::NDIG_W'(1));
  assign out_ovf   = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ndig_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cnt_r   <= CONV_STEPS;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt_r <= cnt_r - r2d_pkg::CNT_W'(1);
          if (cnt_r == r2d_pkg::CNT_W'(1)) begin
            ndig_r  <= ALL_DIGITS;
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros; an all-zero value emits nothing
          if (ndig_r == '0) begin
            state_r <= ST_IDLE;
          end else if (top_digit == 4'd0) begin
            ndig_r <= ndig_r - r2d_pkg::NDIG_W'(1);
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            ndig_r <= ndig_r - r2d_pkg::NDIG_W'(1);
            if (out_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          bin_r <= q_job.value;
          sat_r <= q_job.sat;
          bcd_r <= '0;
        end
      end
      ST_CONV: begin
        {bcd_r, bin_r} <= {bcd_adj, bin_r} << 1;
      end
      ST_SKIP: begin
        if (ndig_r != '0 && top_digit == 4'd0) begin
          bcd_r <= bcd_r << 4;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          bcd_r <= bcd_r << 4;
        end
      end
      default: bcd_r <= bcd_r;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/radix_digits_to_decimal_digits_unit.sv @@
// Radix digit stream to decimal digit stream.
// Input channel in_*: one symbol per word, most significant first. tdata[7:0]
// is the symbol (digit value in binary/octal mode, ASCII in hex mode), tlast
// marks the final symbol of a number. cfg_we/cfg_wdata set the source base
// (0 binary, 1 octal, 2 hex ASCII); write only while the block is idle.
// Output channel out_*: tdata[3:0] one decimal digit, most significant first,
// tlast on the least significant digit, tuser set when the value saturated
// at 2^31-1. A value of zero produces no output words.
// Throughput: one input symbol per cycle while the queue is not full,
// accumulated with a shift and add. A final symbol hands the value to a
// two-entry queue. The converter takes one number at a time from the queue:
// it loads it, runs shift-and-add-3 (one bit per cycle), then drops leading
// zeros and emits one digit per cycle while the receiver keeps up; it takes
// no new number from the queue until it is through with the current one.
// When the receiver stalls, the digit on out_tdata holds; the front keeps
// taking symbols until the queue is full, then drops in_tready.
// Reset (rst_n low, synchronous) clears accumulator, queue and converter and
// sets binary mode.
`default_nettype none
module radix_digits_to_decimal_digits_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,   // radix_mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] symbol
  input  wire logic       in_tlast,    // is_final
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [3:0] dec_digit, [7:4] zero
  output logic            out_tlast,   // last_digit
  output logic            out_tuser    // overflow
);

  r2d_pkg::job_t push_job;
  r2d_pkg::job_t pop_job;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [3:0]    digit;

  r2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_symbol (in_tdata),
    .in_final  (in_tlast),
    .in_ready  (in_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  r2d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  r2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_digit (digit),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

  assign out_tdata = {4'd0, digit};

endmodule
`default_nettype wire

@@ tb/radix_decimal_checker.sv @@
module radix_decimal_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,   // radix_mode
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] symbol
  input  wire logic       in_tlast,    // is_final
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,   // [3:0] dec_digit, [7:4] zero
  input  wire logic       out_tlast,   // last_digit
  input  wire logic       out_tuser,   // overflow
  output int unsigned     mismatches,
  output int unsigned     digits_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
    logic       ovf;
  } dec_word_t;

  dec_word_t                     owed_digits[$];
  logic [1:0]                    radix_sel;
  logic [r2d_pkg::ACC_WIDTH-1:0] running_value;
  logic                          value_saturated;
  int unsigned                   fail_total = 0;

  function automatic longint unsigned radix_base(input logic [1:0] mode);
    case (mode)
      r2d_pkg::MODE_OCT: return 8;
      r2d_pkg::MODE_HEX: return 16;
      default:           return 2;
    endcase
  endfunction

  function automatic longint unsigned symbol_value(input logic [1:0] mode,
                                                   input logic [7:0] sym);
    if (mode != r2d_pkg::MODE_HEX) return sym;
    if (sym >= r2d_pkg::ASCII_ZERO && sym <= r2d_pkg::ASCII_NINE)
      return sym - r2d_pkg::ASCII_ZERO;
    if (sym >= r2d_pkg::ASCII_UPR_A && sym <= r2d_pkg::ASCII_UPR_F)
      return sym - r2d_pkg::ASCII_UPR_A + r2d_pkg::HEX_A_VALUE;
    return 0;
  endfunction

  always @(posedge clk) begin
    dec_word_t         want;
    dec_word_t         next_word;
    longint unsigned   digit;
    longint unsigned   base;
    longint unsigned   rest;
    logic [3:0]        lsd_first[r2d_pkg::MAX_DEC_DIGITS];
    int unsigned       n;
    int unsigned       k;
    if (!rst_n) begin
      radix_sel       = r2d_pkg::MODE_BIN;
      running_value   = '0;
      value_saturated = 1'b0;
      owed_digits.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        digit = symbol_value(radix_sel, in_tdata);
        base  = radix_base(radix_sel);
        if (value_saturated ||
            longint'(running_value) > (longint'(r2d_pkg::ACC_MAX) - digit) / base) begin
          running_value   = r2d_pkg::ACC_MAX;
          value_saturated = 1'b1;
        end else begin
          running_value = r2d_pkg::ACC_WIDTH'(running_value * base + digit);
        end
        if (in_tlast) begin
          rest = running_value;
          n    = 0;
          while (rest != 0 && n < r2d_pkg::MAX_DEC_DIGITS) begin
            lsd_first[n] = 4'(rest % 10);
            rest         = rest / 10;
            n++;
          end
          // queue most significant digit first
          for (k = n; k > 0; k--) begin
            next_word = '{digit: lsd_first[k-1], last: (k == 1), ovf: value_saturated};
            owed_digits = {owed_digits, next_word};
          end
          running_value   = '0;
          value_saturated = 1'b0;
        end
      end
      if (cfg_we) radix_sel = cfg_wdata;

      if (out_tvalid && out_tready) begin
        if (owed_digits.size() == 0) begin
          $error("unexpected output word: tdata %0h tlast %0b tuser %0b",
                 out_tdata, out_tlast, out_tuser);
          fail_total++;
        end else begin
          want = owed_digits.pop_front();
          if (out_tdata !== {4'b0, want.digit}) begin
            $error("dec_digit: expected %0d, actual %0d", {4'b0, want.digit}, out_tdata);
            fail_total++;
          end
          if (out_tlast !== want.last) begin
            $error("last_digit: expected %0b, actual %0b", want.last, out_tlast);
            fail_total++;
          end
          if (out_tuser !== want.ovf) begin
            $error("overflow: expected %0b, actual %0b", want.ovf, out_tuser);
            fail_total++;
          end
        end
      end
    end
    mismatches  <= fail_total;
    digits_owed <= owed_digits.size();
  end

endmodule

@@ tb/tb_radix_digits_to_decimal_digits_unit.sv @@
module tb_radix_digits_to_decimal_digits_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam int unsigned ITEM_TARGET  = 450;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 50;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_wdata  = r2d_pkg::MODE_BIN;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int unsigned mismatches;
  int unsigned digits_owed;
  int unsigned sent = 0;
  logic        calm = 1'b0;
  logic [1:0]  cur_mode = r2d_pkg::MODE_BIN;
  logic [1:0]  radix_cycle[4] = '{r2d_pkg::MODE_BIN, r2d_pkg::MODE_OCT,
                                  r2d_pkg::MODE_HEX, MODE_SPARE};

  always #5 clk = ~clk;

  radix_digits_to_decimal_digits_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  radix_decimal_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .digits_owed (digits_owed)
  );

  task automatic send_word(input logic [7:0] sym, input logic fin, input logic quiet);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digits_owed != 0);
    // let zero-valued numbers still in the queue and converter run out
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [1:0] mode);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = mode;
  endtask

  task automatic send_number();
    int unsigned len;
    int unsigned span;
    int unsigned k;
    int unsigned v;
    logic        zero_run;
    logic        src_quiet;
    logic [7:0]  sym;
    span = (cur_mode == r2d_pkg::MODE_OCT) ? 11 : (cur_mode == r2d_pkg::MODE_HEX) ? 8 : 31;
    case ($urandom_range(0, 9))
      0:       len = 1;
      1, 2:    len = $urandom_range(span, span + 4);
      default: len = $urandom_range(1, span);
    endcase
    zero_run  = ($urandom_range(0, 11) == 0);
    src_quiet = ($urandom_range(0, 2) == 0);
    for (k = 1; k <= len; k++) begin
      v = $urandom_range(0, 15);
      if (zero_run)
        sym = (cur_mode == r2d_pkg::MODE_HEX) ? r2d_pkg::ASCII_ZERO : 8'd0;
      else if ($urandom_range(0, 7) == 0)
        sym = 8'($urandom_range(0, 255));
      else if (cur_mode == r2d_pkg::MODE_HEX)
        sym = (v < 10) ? r2d_pkg::ASCII_ZERO + 8'(v) : r2d_pkg::ASCII_UPR_A + 8'(v - 10);
      else if (cur_mode == r2d_pkg::MODE_OCT)
        sym = 8'(v % 8);
      else
        sym = 8'(v % 2);
      send_word(sym, k == len, src_quiet);
    end
  endtask

  // output side: windows of random stalls mixed with windows of none
  initial begin : sink_ready
    logic quiet;
    forever begin
      quiet = ($urandom_range(0, 2) == 0);
      repeat (40) begin
        @(posedge clk);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_radix(r2d_pkg::MODE_BIN);
    send_word(8'd0, 1'b1, 1'b0);      // zero value: no digits
    send_word(8'd1, 1'b1, 1'b0);
    send_word(8'd255, 1'b1, 1'b0);    // digit far beyond the base

    set_radix(r2d_pkg::MODE_OCT);
    send_word(8'd9, 1'b0, 1'b0);
    send_word(8'd7, 1'b1, 1'b0);

    set_radix(r2d_pkg::MODE_HEX);
    // largest value that fits, then one past it on the final symbol
    send_word(r2d_pkg::ASCII_ZERO + 8'd7, 1'b0, 1'b0);
    repeat (6) send_word(r2d_pkg::ASCII_UPR_F, 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_UPR_F, 1'b1, 1'b0);
    send_word(r2d_pkg::ASCII_ZERO + 8'd8, 1'b0, 1'b0);
    repeat (6) send_word(r2d_pkg::ASCII_ZERO, 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_ZERO, 1'b1, 1'b0);
    // characters just outside the digit ranges, lowercase too
    send_word(r2d_pkg::ASCII_NINE + 8'd1, 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_ZERO - 8'd1, 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_UPR_A - 8'd1, 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_UPR_F + 8'd1, 1'b0, 1'b0);
    send_word("a", 1'b0, 1'b0);
    send_word(r2d_pkg::ASCII_UPR_A, 1'b1, 1'b0);

    set_radix(MODE_SPARE);
    send_word(8'd3, 1'b1, 1'b0);

    phase = 0;
    while (sent < ITEM_TARGET) begin
      set_radix(radix_cycle[(phase < 4) ? phase : $urandom_range(0, 3)]);
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS && sent < ITEM_TARGET) send_number();
      phase++;
    end

    wait_drained();
    if (mismatches == 0 && digits_owed == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
